// ===== design/multichannel_square_wave_sequencer_assert.svh =====
// Assertion macros used by the checker of the tone sequencer.
`ifndef MULTICHANNEL_SQUARE_WAVE_SEQUENCER_ASSERT_SVH
`define MULTICHANNEL_SQUARE_WAVE_SEQUENCER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MSWS_ASSERT_NOW(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MSWS_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/msws_pkg.sv =====
`default_nettype none

package msws_pkg;

   // default build
   localparam int CHANNEL_COUNT_DEF = 4;
   localparam int STEPS_DEF         = 32;
   localparam int NOTE_WIDTH_DEF    = 16;

   // fixed field widths
   localparam int ACTION_W     = 2;
   localparam int TABLE_ADDR_W = 7;
   localparam int DATA_W       = 16;
   localparam int LEVEL_W      = 8;
   localparam int STEP_OUT_W   = 5;
   localparam int PATTERN_W    = 8;
   localparam int PHASE_W      = 16;
   localparam int GAIN_W       = 8;
   localparam int TEMPO_W      = 16;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 24;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int VOLUME_REGS  = 4;
   localparam int VOL_IDX_W    = 2;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TEMPO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VOL0  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VOL3  = 3'd5;

   // register reset values
   localparam logic [TEMPO_W-1:0]   TEMPO_RESET  = 16'd4882;
   localparam logic [PATTERN_W-1:0] LIMIT_RESET  = 8'd20;
   localparam logic [GAIN_W-1:0]    VOLUME_RESET = 8'd63;

   // note codes
   localparam logic [DATA_W-1:0] NOTE_HOLD = 16'd0;
   localparam logic [DATA_W-1:0] NOTE_REST = 16'd1;

   typedef struct packed {
      logic                 tick;
      logic                 restart;
      logic                 advance;
      logic [PATTERN_W-1:0] pattern;   // pattern count after this beat
   } seq_ctl_type;

endpackage

`default_nettype wire

// ===== design/msws_note_bank.sv =====
`default_nettype none

module msws_note_bank #(
   parameter int CH         = 0,
   parameter int STEPS      = msws_pkg::STEPS_DEF,
   parameter int NOTE_WIDTH = msws_pkg::NOTE_WIDTH_DEF,
   parameter int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [msws_pkg::TABLE_ADDR_W-1:0] wr_addr,
   input  wire logic [NOTE_WIDTH-1:0]             wr_data,
   input  wire logic [STEP_W-1:0]                 rd_step,
   output logic      [NOTE_WIDTH-1:0]             note_step,
   output logic      [NOTE_WIDTH-1:0]             note_zero
);
   import msws_pkg::*;

   localparam int BASE   = CH * STEPS;
   localparam int TOP    = (CH + 1) * STEPS;
   localparam int SPAN_W = $clog2(TOP + 1);
   localparam int EXT_W  = (SPAN_W > TABLE_ADDR_W) ? SPAN_W : TABLE_ADDR_W;

   logic [NOTE_WIDTH-1:0] note_mem [STEPS];
   logic [NOTE_WIDTH-1:0] note_step_ff;
   logic [NOTE_WIDTH-1:0] note_zero_ff;
   logic [EXT_W-1:0]      addr_ext;
   logic [EXT_W-1:0]      addr_local;
   logic [STEP_W-1:0]     wa;
   logic                  hit;

   assign addr_ext   = EXT_W'(wr_addr);
   assign hit        = wr_en && (addr_ext >= EXT_W'(BASE)) && (addr_ext < EXT_W'(TOP));
   assign addr_local = addr_ext - EXT_W'(BASE);
   assign wa         = addr_local[STEP_W-1:0];

   always_ff @(posedge clock) begin
      if (hit) begin
         note_mem[wa] <= wr_data;
      end
   end

   // write-through so a word written this cycle is seen by the prefetch
   always_ff @(posedge clock) begin
      if (hit && (wa == rd_step)) begin
         note_step_ff <= wr_data;
      end else begin
         note_step_ff <= note_mem[rd_step];
      end
   end

   // step-0 copy for restart
   always_ff @(posedge clock) begin
      if (hit && (wa == '0)) begin
         note_zero_ff <= wr_data;
      end
   end

   assign note_step = note_step_ff;
   assign note_zero = note_zero_ff;

endmodule

`default_nettype wire

// ===== design/msws_voice.sv =====
`default_nettype none

module msws_voice #(
   parameter int CH         = 0,
   parameter int NOTE_WIDTH = msws_pkg::NOTE_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire msws_pkg::seq_ctl_type          ctl,
   input  wire logic [NOTE_WIDTH-1:0]          note_step,
   input  wire logic [NOTE_WIDTH-1:0]          note_zero,
   input  wire logic [msws_pkg::GAIN_W-1:0]    volume,
   output logic      [msws_pkg::GAIN_W-1:0]    contrib
);
   import msws_pkg::*;

   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [NOTE_WIDTH-1:0] period_ff, period_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [PHASE_W-1:0]    cnt;
   logic [PHASE_W-1:0]    period_ext;
   logic                  high;
   logic                  active;

   assign cnt        = phase_ff + PHASE_W'(1);
   assign period_ext = PHASE_W'(period_ff);
   assign high       = cnt > (period_ext >> 1);
   assign contrib    = high ? gain_ff : '0;
   assign active     = PATTERN_W'(CH) <= (ctl.pattern >> 2);

   always_comb begin
      phase_in  = phase_ff;
      period_in = period_ff;
      gain_in   = gain_ff;
      if (ctl.restart) begin
         phase_in  = '0;
         period_in = note_zero;
         gain_in   = volume;
      end else if (ctl.tick) begin
         phase_in = (high && (cnt >= period_ext)) ? '0 : cnt;
         if (ctl.advance) begin
            if (note_step == NOTE_WIDTH'(NOTE_REST)) begin
               gain_in = '0;
            end else begin
               if (note_step != NOTE_WIDTH'(NOTE_HOLD)) begin
                  period_in = note_step;
               end
               gain_in = active ? volume : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         period_ff <= '0;
         gain_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         period_ff <= period_in;
         gain_ff   <= gain_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/msws_seq.sv =====
`default_nettype none

module msws_seq #(
   parameter int STEPS  = msws_pkg::STEPS_DEF,
   parameter int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           tick,
   input  wire logic                           restart,
   input  wire logic [msws_pkg::TEMPO_W-1:0]   tempo,
   input  wire logic [msws_pkg::PATTERN_W-1:0] limit,
   output msws_pkg::seq_ctl_type               ctl,
   output logic      [STEP_W-1:0]              step_next,
   output logic      [STEP_W-1:0]              rd_step
);
   import msws_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

   logic [TEMPO_W-1:0]   timer_ff, timer_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [PATTERN_W-1:0] pattern_ff, pattern_in;
   logic [PATTERN_W-1:0] pat_inc;
   logic                 step_wrap;
   logic                 advance;

   assign step_wrap = (step_ff == LAST_STEP);
   assign pat_inc   = pattern_ff + PATTERN_W'(1);

   always_comb begin
      timer_in   = timer_ff;
      step_in    = step_ff;
      pattern_in = pattern_ff;
      advance    = 1'b0;
      if (restart) begin
         timer_in   = '0;
         step_in    = '0;
         pattern_in = '0;
      end else if (tick) begin
         if (timer_ff >= tempo) begin
            timer_in = '0;
            advance  = 1'b1;
            step_in  = step_wrap ? '0 : step_ff + STEP_W'(1);
            if (step_wrap) begin
               pattern_in = ((limit != '0) && (pat_inc >= limit)) ? '0 : pat_inc;
            end
         end else begin
            timer_in = timer_ff + TEMPO_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff   <= '0;
         step_ff    <= '0;
         pattern_ff <= '0;
      end else begin
         timer_ff   <= timer_in;
         step_ff    <= step_in;
         pattern_ff <= pattern_in;
      end
   end

   // banks prefetch the step that the next advance moves to
   assign rd_step     = (step_in == LAST_STEP) ? '0 : step_in + STEP_W'(1);
   assign step_next   = step_in;
   assign ctl.tick    = tick;
   assign ctl.restart = restart;
   assign ctl.advance = advance;
   assign ctl.pattern = pattern_in;

endmodule

`default_nettype wire

// ===== design/multichannel_square_wave_sequencer.sv =====
// Multichannel square-wave tone sequencer.
// A request beat moves into the input register, then into the result register once that is
// free; a held result delays it until rsp_tready takes the old beat.
// Throughput: one request beat per cycle while rsp_tready takes each result; the input register
// and the result register let a new beat in while a finished result waits on rsp_tready.
// Reset (synchronous, active high) clears channel and sequencer state and loads
// the register defaults; the note table is not cleared and needs writing before use.
`default_nettype none

module multichannel_square_wave_sequencer #(
   parameter int CHANNEL_COUNT     = msws_pkg::CHANNEL_COUNT_DEF,
   parameter int STEPS_PER_PATTERN = msws_pkg::STEPS_DEF,
   parameter int NOTE_WIDTH        = msws_pkg::NOTE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // action, table_address, table_data
   input  wire logic [msws_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // level, step_index, pattern_count, step_advanced
   output logic      [msws_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [msws_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [msws_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import msws_pkg::*;

   localparam int STEP_W = (STEPS_PER_PATTERN > 1) ? $clog2(STEPS_PER_PATTERN) : 1;

   // configuration registers
   logic [TEMPO_W-1:0]   tempo_ff, tempo_in;
   logic [PATTERN_W-1:0] limit_ff, limit_in;
   logic [GAIN_W-1:0]    vol_ff [VOLUME_REGS];
   logic [GAIN_W-1:0]    vol_in [VOLUME_REGS];
   logic [CSR_IDX_W-1:0] vol_sel;

   // input stage
   logic                    in_valid_ff, in_valid_in;
   logic [ACTION_W-1:0]     in_action_ff;
   logic [TABLE_ADDR_W-1:0] in_addr_ff;
   logic [DATA_W-1:0]       in_data_ff;

   // result stage
   logic                 out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0]   out_level_ff;
   logic [STEP_OUT_W-1:0] out_step_ff;
   logic [PATTERN_W-1:0] out_pattern_ff;
   logic                 out_adv_ff;
   logic [LEVEL_W-1:0]   last_level_ff, last_level_in;

   logic                 fire;
   logic                 tick, restart, wr_en;
   seq_ctl_type          ctl;
   logic [STEP_W-1:0]    step_next, rd_step;
   logic [STEP_W+STEP_OUT_W-1:0] step_wide;
   logic [LEVEL_W-1:0]   mix;
   logic [GAIN_W-1:0]    contrib [CHANNEL_COUNT];
   logic [GAIN_W-1:0]    ch_vol  [CHANNEL_COUNT];
   logic [NOTE_WIDTH-1:0] note_step [CHANNEL_COUNT];
   logic [NOTE_WIDTH-1:0] note_zero [CHANNEL_COUNT];

   // ---------------- configuration ----------------
   assign vol_sel = csr_index - REG_VOL0;

   always_comb begin
      tempo_in = tempo_ff;
      limit_in = limit_ff;
      vol_in   = vol_ff;
      if (csr_we) begin
         unique case (csr_index) inside
            REG_TEMPO:           tempo_in = csr_wdata[TEMPO_W-1:0];
            REG_LIMIT:           limit_in = csr_wdata[PATTERN_W-1:0];
            [REG_VOL0:REG_VOL3]: vol_in[vol_sel[VOL_IDX_W-1:0]] = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff <= TEMPO_RESET;
         limit_ff <= LIMIT_RESET;
         vol_ff   <= '{default: VOLUME_RESET};
      end else begin
         tempo_ff <= tempo_in;
         limit_ff <= limit_in;
         vol_ff   <= vol_in;
      end
   end

   // ---------------- handshake ----------------
   assign fire         = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || fire;
   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= req_tdata[ACTION_W-1:0];
         in_addr_ff   <= req_tdata[ACTION_W +: TABLE_ADDR_W];
         in_data_ff   <= req_tdata[ACTION_W+TABLE_ADDR_W +: DATA_W];
      end
   end

   assign tick    = fire && (in_action_ff == ACT_TICK);
   assign restart = fire && (in_action_ff == ACT_RESTART);
   assign wr_en   = fire && (in_action_ff == ACT_WRITE);

   // ---------------- sequencer ----------------
   msws_seq #(
      .STEPS (STEPS_PER_PATTERN),
      .STEP_W(STEP_W)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .tick     (tick),
      .restart  (restart),
      .tempo    (tempo_ff),
      .limit    (limit_ff),
      .ctl      (ctl),
      .step_next(step_next),
      .rd_step  (rd_step)
   );

   // ---------------- channels ----------------
   for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_ch
      if (c < VOLUME_REGS) begin : g_vol
         assign ch_vol[c] = vol_ff[c];
      end else begin : g_novol
         assign ch_vol[c] = '0;
      end

      msws_note_bank #(
         .CH        (c),
         .STEPS     (STEPS_PER_PATTERN),
         .NOTE_WIDTH(NOTE_WIDTH),
         .STEP_W    (STEP_W)
      ) u_bank (
         .clock    (clock),
         .wr_en    (wr_en),
         .wr_addr  (in_addr_ff),
         .wr_data  (in_data_ff[NOTE_WIDTH-1:0]),
         .rd_step  (rd_step),
         .note_step(note_step[c]),
         .note_zero(note_zero[c])
      );

      msws_voice #(
         .CH        (c),
         .NOTE_WIDTH(NOTE_WIDTH)
      ) u_voice (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .note_step(note_step[c]),
         .note_zero(note_zero[c]),
         .volume   (ch_vol[c]),
         .contrib  (contrib[c])
      );
   end

   // level wraps mod 256
   always_comb begin
      mix = '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         mix = mix + contrib[c];
      end
   end

   assign last_level_in = tick ? mix : last_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= '0;
      end else begin
         last_level_ff <= last_level_in;
      end
   end

   // ---------------- result ----------------
   assign step_wide = {{STEP_OUT_W{1'b0}}, step_next};

   always_ff @(posedge clock) begin
      if (fire) begin
         out_level_ff   <= last_level_in;
         out_step_ff    <= step_wide[STEP_OUT_W-1:0];
         out_pattern_ff <= ctl.pattern;
         out_adv_ff     <= ctl.advance;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_adv_ff, out_pattern_ff, out_step_ff, out_level_ff};

endmodule

`default_nettype wire

// ===== design/msws_checker.sv =====
`default_nettype none
`include "multichannel_square_wave_sequencer_assert.svh"

module msws_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [msws_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result beat holds
   `MSWS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")

   // valid only drops after a taken beat
   `MSWS_ASSERT_NOW(a_rsp_drop, $fell(rsp_tvalid) && !$past(reset), $past(rsp_tready), "rsp_tvalid dropped without a handshake")

   // with the result register empty the input stage must be able to drain
   `MSWS_ASSERT_NOW(a_req_ready, !rsp_tvalid, req_tready, "req_tready low while result register empty")

   // every accepted request beat is followed by a result beat on offer
   `MSWS_ASSERT_NOW(a_rsp_follow, $past(req_tvalid && req_tready, 2) && !$past(reset, 1) && !$past(reset, 2), rsp_tvalid, "no result beat after accepted request")

endmodule

bind multichannel_square_wave_sequencer msws_checker u_checker (.*);

`default_nettype wire

// ===== test/tb_multichannel_square_wave_sequencer.sv =====
`default_nettype none

module tb_multichannel_square_wave_sequencer;
   import msws_pkg::*;

   localparam int CHANNELS    = CHANNEL_COUNT_DEF;
   localparam int STEPS       = STEPS_DEF;
   localparam int TABLE_DEPTH = CHANNELS * STEPS;
   localparam int IDLE_LIMIT  = 1000;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   class tone_scoreboard;
      logic [TEMPO_W-1:0]   tempo;
      logic [PATTERN_W-1:0] limit;
      logic [GAIN_W-1:0]    volume [VOLUME_REGS];
      logic [PHASE_W-1:0]   phase_cnt [CHANNELS];
      logic [DATA_W-1:0]    period [CHANNELS];
      logic [GAIN_W-1:0]    gain [CHANNELS];
      logic [TEMPO_W-1:0]   timer;
      int                   step_pos;
      logic [PATTERN_W-1:0] pattern;
      logic [DATA_W-1:0]    notes [TABLE_DEPTH];
      logic [LEVEL_W-1:0]   last_level;
      logic [RSP_TDATA_W-1:0] expected_beats [$];
      int errors, ticks, advances, restarts, table_writes, max_pattern;

      function void reset_state();
         tempo = TEMPO_RESET;
         limit = LIMIT_RESET;
         for (int v = 0; v < VOLUME_REGS; v++) volume[v] = VOLUME_RESET;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            phase_cnt[ch] = '0;
            period[ch]    = '0;
            gain[ch]      = '0;
         end
         for (int a = 0; a < TABLE_DEPTH; a++) notes[a] = '0;
         timer      = '0;
         step_pos   = 0;
         pattern    = '0;
         last_level = '0;
      endfunction

      function void write_reg(int idx, logic [CSR_DATA_W-1:0] val);
         if (idx == REG_TEMPO)
            tempo = val;
         else if (idx == REG_LIMIT)
            limit = val[PATTERN_W-1:0];
         else if (idx >= REG_VOL0 && idx <= REG_VOL3)
            volume[idx - REG_VOL0] = val[GAIN_W-1:0];
      endfunction

      function logic [GAIN_W-1:0] volume_of(int ch);
         return (ch < VOLUME_REGS) ? volume[ch] : '0;
      endfunction

      // next sequencer state for one accepted request beat, queues the result it causes
      function void advance_sequencer(logic [ACTION_W-1:0] act, logic [TABLE_ADDR_W-1:0] addr,
                                      logic [DATA_W-1:0] data);
         logic [LEVEL_W-1:0]   level;
         logic [PHASE_W-1:0]   c;
         logic [PATTERN_W-1:0] n;
         logic [DATA_W-1:0]    note;
         logic                 adv;
         adv = 1'b0;
         if (act == ACT_WRITE) begin
            if (addr < TABLE_DEPTH) notes[addr] = data;
            table_writes++;
         end else if (act == ACT_RESTART) begin
            timer    = '0;
            step_pos = 0;
            pattern  = '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
               phase_cnt[ch] = '0;
               period[ch]    = notes[ch * STEPS];
               gain[ch]      = volume_of(ch);
            end
            restarts++;
         end else if (act == ACT_TICK) begin
            level = '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
               c = phase_cnt[ch] + 1'b1;
               if (c > (period[ch] >> 1)) begin
                  if (c >= period[ch]) c = '0;
                  level = level + gain[ch];
               end
               phase_cnt[ch] = c;
            end
            last_level = level;
            ticks++;
            if (timer >= tempo) begin
               timer = '0;
               adv   = 1'b1;
               advances++;
               step_pos++;
               if (step_pos >= STEPS) begin
                  n = pattern + 1'b1;
                  // a limit of zero lets the count run round 256
                  if (limit != 0 && n >= limit) n = '0;
                  pattern  = n;
                  step_pos = 0;
               end
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  note = notes[ch * STEPS + step_pos];
                  if (note == NOTE_REST) begin
                     gain[ch] = '0;
                  end else begin
                     if (note != NOTE_HOLD) period[ch] = note;
                     gain[ch] = (ch <= pattern / 4) ? volume_of(ch) : '0;
                  end
               end
            end else begin
               timer = timer + 1'b1;
            end
         end
         if (pattern > max_pattern) max_pattern = int'(pattern);
         expected_beats.push_back({2'b00, adv, pattern, 5'(step_pos), last_level});
      endfunction

      function void report_field(string name, int e, int a);
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
         errors++;
      endfunction

      function void compare_beat(logic [RSP_TDATA_W-1:0] got);
         logic [RSP_TDATA_W-1:0] want;
         if (expected_beats.size() == 0) begin
            $display("%0t: result beat %h with nothing expected", $time, got);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         if (got[7:0] !== want[7:0])
            report_field("level", int'(want[7:0]), int'(got[7:0]));
         if (got[12:8] !== want[12:8])
            report_field("step_index", int'(want[12:8]), int'(got[12:8]));
         if (got[20:13] !== want[20:13])
            report_field("pattern_count", int'(want[20:13]), int'(got[20:13]));
         if (got[21] !== want[21])
            report_field("step_advanced", int'(want[21]), int'(got[21]));
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic no_idle = 1'b0;
   int   rsp_hold = 0;
   int   idle_cycles = 0;
   tone_scoreboard sb;

   multichannel_square_wave_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side: random stall after each beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         sb.compare_beat(rsp_tdata);
         rsp_hold = no_idle ? 0 : $urandom_range(0, 3);
         rsp_tready <= (rsp_hold == 0);
      end else if (!rsp_tready) begin
         if (rsp_hold > 0) rsp_hold--;
         rsp_tready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [TABLE_ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {7'd0, data, addr, act};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.advance_sequencer(act, addr, data);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input logic [TEMPO_W-1:0] tempo, input logic [PATTERN_W-1:0] lim,
                               input logic [GAIN_W-1:0] v0, input logic [GAIN_W-1:0] v1,
                               input logic [GAIN_W-1:0] v2, input logic [GAIN_W-1:0] v3);
      logic [CSR_DATA_W-1:0] vals [REG_VOL3+1];
      vals[REG_TEMPO]    = tempo;
      vals[REG_LIMIT]    = CSR_DATA_W'(lim);
      vals[REG_VOL0]     = CSR_DATA_W'(v0);
      vals[REG_VOL0 + 1] = CSR_DATA_W'(v1);
      vals[REG_VOL0 + 2] = CSR_DATA_W'(v2);
      vals[REG_VOL0 + 3] = CSR_DATA_W'(v3);
      for (int i = REG_TEMPO; i <= REG_VOL3; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[CSR_IDX_W-1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(i, vals[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] random_note();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return NOTE_HOLD;
      if (r < 30) return NOTE_REST;
      if (r < 85) return DATA_W'($urandom_range(2, 64));
      return DATA_W'($urandom);
   endfunction

   task automatic random_item(input int restart_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < restart_pct)
         send_item(ACT_RESTART, 7'($urandom), 16'($urandom));
      else if (r < restart_pct + 3)
         send_item(ACT_UNUSED, 7'($urandom), 16'($urandom));
      else if (r < restart_pct + 15)
         send_item(ACT_WRITE, 7'($urandom), random_note());
      else
         send_item(ACT_TICK, 7'($urandom), 16'($urandom));
   endtask

   initial begin
      logic [DATA_W-1:0] d;
      int tempos [5]   = '{0, 1, 65535, 20, 2};
      int limits [5]   = '{255, 3, 1, 20, 255};
      int counts [9]   = '{600, 150, 100, 150, 150, 140, 140, 140, 140};
      int rst_pct [9]  = '{0, 3, 5, 3, 3, 3, 3, 3, 3};

      sb = new;
      sb.reset_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ticks on reset defaults, the unused code, then fill the table
      send_item(ACT_TICK, 7'h00, 16'h0000);
      send_item(ACT_TICK, 7'h7F, 16'hFFFF);
      send_item(ACT_UNUSED, 7'h7F, 16'hFFFF);
      for (int a = 0; a < TABLE_DEPTH; a++) begin
         // step-0 words: zero period, raw period one, longest period, shortest tone
         if (a % STEPS == 0)
            case (a / STEPS)
               0:       d = NOTE_HOLD;
               1:       d = NOTE_REST;
               2:       d = 16'hFFFF;
               default: d = 16'd2;
            endcase
         else
            d = random_note();
         send_item(ACT_WRITE, a[TABLE_ADDR_W-1:0], d);
      end
      send_item(ACT_RESTART, 7'h00, 16'h0000);
      repeat (8) send_item(ACT_TICK, 7'($urandom), 16'($urandom));
      drain();
      apply_config(16'd0, 8'd2, 8'd0, 8'd255, 8'd128, 8'd1);
      send_item(ACT_RESTART, 7'h55, 16'hAAAA);
      repeat (12) send_item(ACT_TICK, 7'h2A, 16'h5555);

      for (int p = 0; p < 9; p++) begin
         drain();
         no_idle <= (p % 3 == 2);
         if (p == 0)
            apply_config(TEMPO_W'(tempos[p]), PATTERN_W'(limits[p]), 8'd255, 8'd255, 8'd255,
                         8'd255);
         else if (p == 1)
            apply_config(TEMPO_W'(tempos[p]), PATTERN_W'(limits[p]), 8'd0, 8'd17, 8'd128,
                         8'd255);
         else if (p < 5)
            apply_config(TEMPO_W'(tempos[p]), PATTERN_W'(limits[p]), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
         else
            apply_config(TEMPO_W'($urandom_range(0, 7)), PATTERN_W'($urandom_range(1, 255)),
                         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         // the long first phase runs without restarts so the pattern count climbs far
         repeat (counts[p]) random_item(rst_pct[p]);
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Ran %0d ticks with %0d step advances, %0d restarts and %0d table writes.",
               sb.ticks, sb.advances, sb.restarts, sb.table_writes);
      $display("Highest pattern count reached: %0d; mismatches: %0d.", sb.max_pattern, sb.errors);
      if (sb.errors == 0 && sb.expected_beats.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
